// ===== hw/rtl/vt4_pkg.sv =====
`default_nettype none
package vt4_pkg;

    localparam int COEF_W    = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = COEF_W + DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    // Widest rounded sum over the legal coefficient formats.
    localparam int CLAMP_W   = ACC_W - 8;
    localparam int Q_W       = DATA_W;
    localparam int CFG_N     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam int COEF_FRAC_BITS_DEF = 12;
    localparam int DATA_FRAC_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_W = 2'd3;

    localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
        logic signed [DATA_W-1:0] in_w;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     divide_by_zero;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic              [DATA_W-1:0] value;
        logic                           sat;
    } t_clamp;

    // Side data that travels alongside the divider pipeline.
    typedef struct packed {
        logic              cmd;
        logic              dbz;
        logic              sat;
        logic [2:0]        neg;
        logic [2:0]        ovf;
        logic [DATA_W-1:0] cx;
        logic [DATA_W-1:0] cy;
        logic [DATA_W-1:0] cz;
        logic [DATA_W-1:0] cw;
    } t_side;

    function automatic t_clamp clamp32(input logic signed [CLAMP_W-1:0] v);
        t_clamp r;
        if (v > CLAMP_W'($signed(DATA_MAX))) begin
            r.value = DATA_MAX;
            r.sat   = 1'b1;
        end else if (v < -(CLAMP_W'(signed'(1)) <<< (DATA_W - 1))) begin
            r.value = DATA_MIN;
            r.sat   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vt4_mac.sv =====
`default_nettype none
module vt4_mac
    import vt4_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int DATA_FRAC_BITS = DATA_FRAC_BITS_DEF,
    parameter int SUM_W          = ACC_W - COEF_FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire t_in_item                       i_item,
    input  wire logic [CFG_N-1:0][CFG_W-1:0]    i_coef,
    output logic                                o_valid,
    output logic                                o_cmd,
    output logic signed [SUM_W-1:0]             o_sum [CFG_N]
);

    logic signed [DATA_W-1:0] ops [CFG_N];
    logic signed [PROD_W-1:0] r_prod [CFG_N][CFG_N];
    logic signed [PROD_W:0]   r_pair [CFG_N][2];
    logic signed [SUM_W-1:0]  r_sum  [CFG_N];
    logic signed [ACC_W-1:0]  acc    [CFG_N];
    logic [2:0]               r_vld;
    logic [2:0]               r_cmd;

    // In point mode the fourth operand is exactly 1.0.
    always_comb begin
        ops[0] = i_item.in_x;
        ops[1] = i_item.in_y;
        ops[2] = i_item.in_z;
        ops[3] = i_item.cmd ? i_item.in_w
                            : (DATA_W'(signed'(1)) <<< DATA_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CFG_N; j++) begin
            for (int i = 0; i < CFG_N; i++) begin
                r_prod[j][i] <= $signed(i_coef[j][COEF_W*i +: COEF_W]) * ops[i];
            end
            r_pair[j][0] <= (PROD_W+1)'(r_prod[j][0]) + (PROD_W+1)'(r_prod[j][1]);
            r_pair[j][1] <= (PROD_W+1)'(r_prod[j][2]) + (PROD_W+1)'(r_prod[j][3]);
        end
    end

    // Round half up, then drop the coefficient fraction.
    always_comb begin
        for (int j = 0; j < CFG_N; j++) begin
            acc[j] = ACC_W'(r_pair[j][0]) + ACC_W'(r_pair[j][1])
                   + (ACC_W'(signed'(1)) <<< (COEF_FRAC_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CFG_N; j++) begin
            r_sum[j] <= acc[j][ACC_W-1:COEF_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= {r_cmd[1:0], i_item.cmd};
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_cmd   = r_cmd[2];
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

// ===== hw/rtl/vt4_div.sv =====
`default_nettype none
module vt4_div
    import vt4_pkg::*;
#(
    parameter int DATA_FRAC_BITS = DATA_FRAC_BITS_DEF,
    parameter int SUM_W          = ACC_W - COEF_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic [SUM_W-1:0]   i_num,
    input  wire logic [SUM_W-1:0]   i_den,
    output logic      [Q_W-1:0]     o_quot
);

    localparam int NW = SUM_W + DATA_FRAC_BITS;

    logic [NW-1:0]    nfull;
    logic [SUM_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]   r_low  [Q_W];
    logic [Q_W-1:0]   r_q    [Q_W];
    logic [SUM_W-1:0] r_d    [Q_W];

    // The numerator is scaled by the data fraction; its upper part seeds the
    // remainder and the low word is fed in one bit per stage.
    assign nfull = {i_num, {DATA_FRAC_BITS{1'b0}}};

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [SUM_W-1:0] rem_in;
        logic [Q_W-1:0]   low_in;
        logic [Q_W-1:0]   q_in;
        logic [SUM_W-1:0] d_in;
        logic [SUM_W:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = SUM_W'(nfull[NW-1:Q_W]);
            assign low_in = nfull[Q_W-1:0];
            assign q_in   = '0;
            assign d_in   = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
        end

        assign trial = {rem_in, low_in[Q_W-1-k]};
        assign take  = trial >= {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? SUM_W'(trial - {1'b0, d_in}) : trial[SUM_W-1:0];
            r_low[k] <= low_in;
            r_q[k]   <= {q_in[Q_W-2:0], take};
            r_d[k]   <= d_in;
        end
    end

    assign o_quot = r_q[Q_W-1];

endmodule
`default_nettype wire

// ===== hw/rtl/vertex_transform_4x4_core.sv =====
`default_nettype none
// Homogeneous 4x4 vertex transform in fixed point.
//
// Configuration: four 64-bit column registers, each holding four signed
// coefficients, are written through i_cfg_we, i_cfg_idx and i_cfg_data.
// A write takes effect at the clock edge and should only happen while no
// vertex is in flight. Reset loads the identity matrix.
//
// Input: a vertex transfer happens at each edge where i_start is high and
// o_busy is low. o_busy is always low, so one vertex can enter every cycle.
//
// Output: each result is shown on o_result for exactly one cycle with
// o_done high. The receiver cannot hold results off, and none is needed:
// every transfer in gives exactly one transfer out, in order.
//
// The pipeline has three multiply and sum stages, one stage that
// forms magnitudes and clamps, 32 stages of a restoring divider that
// produces one quotient bit each, and the output register. Throughput is
// one vertex per cycle. Reset empties the pipeline; items in flight are
// dropped.
module vertex_transform_4x4_core
    import vt4_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int DATA_FRAC_BITS = DATA_FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire t_in_item               i_in,
    output logic                        o_done,
    output t_out_item                   o_result,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    localparam int SUM_W = ACC_W - COEF_FRAC_BITS;
    localparam int SH    = DATA_W - DATA_FRAC_BITS;
    localparam int LAT   = 4 + Q_W + 1;

    logic [CFG_N-1:0][CFG_W-1:0] r_coef;

    // The column registers reset to the identity matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[CFG_COL_X] <= CFG_W'(1) << COEF_FRAC_BITS;
            r_coef[CFG_COL_Y] <= CFG_W'(1) << (COEF_FRAC_BITS + COEF_W);
            r_coef[CFG_COL_Z] <= CFG_W'(1) << (COEF_FRAC_BITS + 2*COEF_W);
            r_coef[CFG_COL_W] <= CFG_W'(1) << (COEF_FRAC_BITS + 3*COEF_W);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COL_X: r_coef[CFG_COL_X] <= i_cfg_data;
                CFG_COL_Y: r_coef[CFG_COL_Y] <= i_cfg_data;
                CFG_COL_Z: r_coef[CFG_COL_Z] <= i_cfg_data;
                CFG_COL_W: r_coef[CFG_COL_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Every stage advances each cycle, so a new vertex is always welcome.
    assign o_busy = 1'b0;

    logic                    mac_vld;
    logic                    mac_cmd;
    logic signed [SUM_W-1:0] mac_sum [CFG_N];

    vt4_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .DATA_FRAC_BITS (DATA_FRAC_BITS),
        .SUM_W          (SUM_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_item  (i_in),
        .i_coef  (r_coef),
        .o_valid (mac_vld),
        .o_cmd   (mac_cmd),
        .o_sum   (mac_sum)
    );

    // Prep stage: magnitudes and signs for the divide, overflow of the
    // integer part, and the clamped sums (all four in vector mode, w in point mode).
    t_side            n_side;
    logic [SUM_W-1:0] n_mag [CFG_N];
    logic [SUM_W-1:0] r_mag [CFG_N];
    t_clamp           cl    [CFG_N];
    logic             w_zero;

    always_comb begin
        for (int j = 0; j < CFG_N; j++) begin
            cl[j]    = clamp32(CLAMP_W'(mac_sum[j]));
            n_mag[j] = mac_sum[j][SUM_W-1] ? SUM_W'(-mac_sum[j]) : SUM_W'(mac_sum[j]);
        end
        w_zero     = mac_sum[3] == '0;
        n_side.cmd = mac_cmd;
        n_side.dbz = !mac_cmd && w_zero;
        for (int j = 0; j < 3; j++) begin
            n_side.neg[j] = mac_sum[j][SUM_W-1] ^ mac_sum[3][SUM_W-1];
            n_side.ovf[j] = (SUM_W+SH)'(n_mag[j]) >= {n_mag[3], {SH{1'b0}}};
        end
        n_side.cx = cl[0].value;
        n_side.cy = cl[1].value;
        n_side.cz = cl[2].value;
        if (mac_cmd) begin
            n_side.cw  = cl[3].value;
            n_side.sat = cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
        end else if (w_zero) begin
            n_side.cw  = '0;
            n_side.sat = 1'b0;
        end else begin
            n_side.cw  = cl[3].value;
            n_side.sat = cl[3].sat;
        end
    end

    // Side data and valid bits ride along with the divider stages.
    t_side      r_side [Q_W+1];
    logic [Q_W:0] r_vld;

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int k = 1; k <= Q_W; k++) begin
            r_side[k] <= r_side[k-1];
        end
        for (int j = 0; j < CFG_N; j++) begin
            r_mag[j] <= n_mag[j];
        end
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Q_W-1:0], mac_vld};
        end
    end

    logic [Q_W-1:0] quot [3];

    for (genvar j = 0; j < 3; j++) begin : g_div
        vt4_div #(
            .DATA_FRAC_BITS (DATA_FRAC_BITS),
            .SUM_W          (SUM_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (r_mag[j]),
            .i_den  (r_mag[3]),
            .o_quot (quot[j])
        );
    end

    // Output stage: apply signs, clamp the quotients and pick the mode.
    t_side          last;
    logic [DATA_W-1:0] dq   [3];
    logic [2:0]        dsat;
    t_out_item         n_result;
    t_out_item         r_result;
    logic              r_done;

    assign last = r_side[Q_W];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (last.ovf[j]) begin
                dsat[j] = 1'b1;
                dq[j]   = last.neg[j] ? DATA_MIN : DATA_MAX;
            end else if (last.neg[j]) begin
                dsat[j] = quot[j] > DATA_MIN;
                dq[j]   = dsat[j] ? DATA_MIN : -quot[j];
            end else begin
                dsat[j] = quot[j][Q_W-1];
                dq[j]   = dsat[j] ? DATA_MAX : quot[j];
            end
        end
        n_result.out_w          = last.cw;
        n_result.divide_by_zero = last.dbz;
        if (last.cmd) begin
            n_result.out_x     = last.cx;
            n_result.out_y     = last.cy;
            n_result.out_z     = last.cz;
            n_result.saturated = last.sat;
        end else if (last.dbz) begin
            n_result.out_x     = '0;
            n_result.out_y     = '0;
            n_result.out_z     = '0;
            n_result.saturated = 1'b0;
        end else begin
            n_result.out_x     = dq[0];
            n_result.out_y     = dq[1];
            n_result.out_z     = dq[2];
            n_result.saturated = last.sat | (|dsat);
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[Q_W];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("accepted vertex did not complete after the pipeline latency");

    a_no_orphan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result appeared without a matching accepted vertex");

    a_dbz_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.divide_by_zero) |->
        (!o_result.saturated && o_result.out_w == '0 && o_result.out_x == '0))
        else $error("zero-w result is not cleared");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
// Self-checking bench for vertex_transform_4x4_core.
module tb;
    import vt4_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes carried in the cmd field of an input transfer.
    localparam logic CMD_POINT  = 1'b0;
    localparam logic CMD_VECTOR = 1'b1;

    // Covers the core's pipeline depth, output register included, with slack to spare.
    localparam int DRAIN_CYCLES = 45;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    t_in_item             i_in = '0;
    logic                 o_done;
    t_out_item            o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_COL_X;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    vertex_transform_4x4_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The scoreboard holds a copy of the four matrix columns and predicts
    // every transformed vertex the moment its input transfer is accepted.
    class vertex_scoreboard;
        logic [CFG_W-1:0] column[4];
        t_out_item        pending[$];
        int               errors;
        int               checked;
        int               accepted;

        function new();
            column[0] = 64'h1000;
            column[1] = 64'h1000 << 16;
            column[2] = 64'h1000 << 32;
            column[3] = 64'h1000 << 48;
        endfunction

        // Exact sum of four products, rounded half up to the data format.
        function longint dot_rounded(logic [CFG_W-1:0] col, longint v[4]);
            longint acc;
            acc = 0;
            for (int i = 0; i < 4; i++)
                acc += longint'($signed(col[16*i +: 16])) * v[i];
            return (acc + 2048) >>> 12;
        endfunction

        function logic [31:0] clamp(longint v, inout bit sat);
            if (v > 64'sh7FFF_FFFF) begin
                sat = 1'b1;
                return DATA_MAX;
            end
            if (v < -64'sh8000_0000) begin
                sat = 1'b1;
                return DATA_MIN;
            end
            return v[31:0];
        endfunction

        // num / den with 16 fraction bits, truncated toward zero, clamped.
        function logic [31:0] divide(longint num, longint den, inout bit sat);
            logic [127:0] n;
            logic [127:0] d;
            logic [127:0] q;
            bit           neg;
            neg = (num < 0) != (den < 0);
            n = 128'(num < 0 ? -num : num);
            d = 128'(den < 0 ? -den : den);
            q = (n << 16) / d;
            if (!neg) begin
                if (q > 128'h7FFF_FFFF) begin
                    sat = 1'b1;
                    return DATA_MAX;
                end
                return q[31:0];
            end
            if (q > 128'h8000_0000) begin
                sat = 1'b1;
                return DATA_MIN;
            end
            return -q[31:0];
        endfunction

        function void note_input(t_in_item it);
            longint    v[4];
            longint    sx, sy, sz, sw;
            bit        sat;
            t_out_item r;
            sat = 1'b0;
            r = '0;
            v[0] = it.in_x;
            v[1] = it.in_y;
            v[2] = it.in_z;
            // Point mode replaces w with exactly 1.0.
            v[3] = (it.cmd == CMD_POINT) ? 64'sd65536 : longint'(it.in_w);
            sx = dot_rounded(column[0], v);
            sy = dot_rounded(column[1], v);
            sz = dot_rounded(column[2], v);
            sw = dot_rounded(column[3], v);
            if (it.cmd == CMD_VECTOR) begin
                r.out_x = clamp(sx, sat);
                r.out_y = clamp(sy, sat);
                r.out_z = clamp(sz, sat);
                r.out_w = clamp(sw, sat);
            end else if (sw == 0) begin
                r.divide_by_zero = 1'b1;
            end else begin
                r.out_x = divide(sx, sw, sat);
                r.out_y = divide(sy, sw, sat);
                r.out_z = divide(sz, sw, sat);
                r.out_w = clamp(sw, sat);
            end
            r.saturated = sat;
            pending.push_back(r);
            accepted++;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("tb: mismatch on %s: got %h, expected %h (result %0d)",
                     what, got, want, checked);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("unexpected result", got.out_x, '0);
                return;
            end
            want = pending.pop_front();
            if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
            if (got.out_w !== want.out_w) report("out_w", got.out_w, want.out_w);
            if (got.divide_by_zero !== want.divide_by_zero)
                report("divide_by_zero", 32'(got.divide_by_zero),
                       32'(want.divide_by_zero));
            if (got.saturated !== want.saturated)
                report("saturated", 32'(got.saturated), 32'(want.saturated));
            checked++;
        endtask
    endclass

    vertex_scoreboard sb = new();
    int               settings_used = 1;

    // Both transfers are sampled at the edge itself, before any driver update
    // made at that edge lands, so the order of processes does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                sb.note_input(i_in);
            if (o_done)
                sb.check_result(o_result);
        end
    end

    // Present one vertex and hold it until the core takes it. The start line
    // stays high so that back-to-back transfers form a burst.
    task send_vertex(t_in_item it);
        i_start <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_busy);
    endtask

    task idle(int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Only called with the pipeline empty, so the scoreboard can take the
    // new matrix at once.
    task write_matrix(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                      logic [CFG_W-1:0] cz, logic [CFG_W-1:0] cw);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [CFG_W-1:0]     val[4];
        idx = '{CFG_COL_X, CFG_COL_Y, CFG_COL_Z, CFG_COL_W};
        val = '{cx, cy, cz, cw};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
            sb.column[i] = val[i];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task drain();
        idle(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A component drawn from full range, small magnitudes (so divides
    // usually stay in range) or the corner values.
    function logic [31:0] rand_component();
        logic [31:0] small_mag;
        small_mag = $urandom_range(0, 1 << 22);
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2, 3: return $urandom_range(0, 1) ? small_mag : -small_mag;
            4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom());
            2: return 16'($signed(16'($urandom_range(0, 8192))) - 16'sd4096);
            3: return 16'h1000;
            4: return 16'h0;
            default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    function logic [CFG_W-1:0] rand_column();
        return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function t_in_item make_vertex(logic cmd, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic [31:0] w);
        t_in_item it;
        it.cmd  = cmd;
        it.in_x = x;
        it.in_y = y;
        it.in_z = z;
        it.in_w = w;
        return it;
    endfunction

    // Random bursts of random vertices separated by random gaps; some
    // stretches run with no gap at all.
    task random_vertices(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_vertex(make_vertex($urandom_range(0, 1) ? CMD_VECTOR : CMD_POINT,
                                        rand_component(), rand_component(),
                                        rand_component(), rand_component()));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 6));
        end
    endtask

    task directed_vertices();
        logic [31:0] corner[6];
        corner = '{32'h0, DATA_MAX, DATA_MIN, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000};
        for (int k = 0; k < 6; k++) begin
            send_vertex(make_vertex(CMD_POINT, corner[k], corner[(k + 1) % 6],
                                    corner[(k + 2) % 6], corner[(k + 3) % 6]));
            send_vertex(make_vertex(CMD_VECTOR, corner[k], corner[(k + 2) % 6],
                                    corner[(k + 4) % 6], corner[(k + 5) % 6]));
        end
        // All ones, all maximum and all minimum on every field.
        send_vertex(make_vertex(CMD_VECTOR, '1, '1, '1, '1));
        send_vertex(make_vertex(CMD_VECTOR, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
        send_vertex(make_vertex(CMD_POINT, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity matrix straight out of reset.
        directed_vertices();
        random_vertices(300);
        drain();

        // Largest positive coefficients everywhere: heavy saturation.
        write_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        random_vertices(250);
        drain();

        // Most negative coefficients everywhere.
        write_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        random_vertices(250);
        drain();

        // A zero w column: every point-mode vertex hits the zero w case.
        write_matrix(rand_column(), rand_column(), rand_column(), 64'h0);
        directed_vertices();
        random_vertices(200);
        drain();

        // A scaled identity with an x term in the w row, then fully
        // random matrices.
        write_matrix(64'h0000_0000_0000_2000, 64'h0000_0000_E000_0000,
                     64'h0000_1000_0000_0000, 64'h1000_0000_0000_0800);
        random_vertices(250);
        drain();
        for (int m = 0; m < 4; m++) begin
            write_matrix(rand_column(), rand_column(), rand_column(), rand_column());
            random_vertices(190);
            drain();
        end

        $display("tb: %0d vertices accepted, %0d results checked", sb.accepted, sb.checked);
        $display("tb: %0d matrix settings, point and vector mode, corners and zero w",
                 settings_used);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
